### rtl/mcop_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, coefficient tables and sequencer program for the option payoff block.
package mcop_pkg;

    localparam logic [47:0] PRICE_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [24:0] ONE_Q24     = 25'h100_0000;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [32:0] TWO_LN2_Q30 = 33'd1488522236;
    localparam logic [32:0] LN2_Q30     = 33'd744261118;
    localparam logic [32:0] INV_LN2_Q30 = 33'd1549082005;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;

    localparam logic [2:0] REG_DRIFT  = 3'd0;
    localparam logic [2:0] REG_VOL    = 3'd1;
    localparam logic [2:0] REG_STRIKE = 3'd2;
    localparam logic [2:0] REG_CALL   = 3'd3;
    localparam logic [2:0] REG_DISC   = 3'd4;

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP     = 5'd0;
    localparam op_t OP_CAPTURE = 5'd1;
    localparam op_t OP_LOAD    = 5'd2;
    localparam op_t OP_NORM    = 5'd3;
    localparam op_t OP_SQ      = 5'd4;
    localparam op_t OP_LOGL    = 5'd5;
    localparam op_t OP_R2      = 5'd6;
    localparam op_t OP_SQRT    = 5'd7;
    localparam op_t OP_TH      = 5'd8;
    localparam op_t OP_Y       = 5'd9;
    localparam op_t OP_CH      = 5'd10;
    localparam op_t OP_Z       = 5'd11;
    localparam op_t OP_W       = 5'd12;
    localparam op_t OP_X       = 5'd13;
    localparam op_t OP_G       = 5'd14;
    localparam op_t OP_EH      = 5'd15;
    localparam op_t OP_D1      = 5'd16;
    localparam op_t OP_D2      = 5'd17;
    localparam op_t OP_PRICE   = 5'd18;
    localparam op_t OP_PAY     = 5'd19;
    localparam op_t OP_ACC     = 5'd20;
    localparam op_t OP_DIVI    = 5'd21;
    localparam op_t OP_DIV     = 5'd22;
    localparam op_t OP_MP1     = 5'd23;
    localparam op_t OP_MP2     = 5'd24;
    localparam op_t OP_MP3     = 5'd25;
    localparam op_t OP_EMIT    = 5'd26;

    typedef logic [4:0] pc_t;

    localparam pc_t PC_LANE_LAST  = 5'd18;
    localparam pc_t PC_FINAL      = 5'd19;
    localparam pc_t PC_FINAL_LAST = 5'd23;

    typedef struct packed {
        op_t        op;
        logic       phase;
        logic [5:0] step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

    typedef struct packed {
        logic [47:0] drift_scale;
        logic [31:0] vol_scale;
        logic [47:0] strike;
        logic        is_call;
        logic [24:0] discount;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] reps;
    } prog_t;

    function automatic logic op_is_mul(op_t op);
        logic r;
        unique case (op) inside
            OP_SQ, OP_R2, OP_TH, OP_Y, OP_CH, OP_Z, OP_W, OP_X, OP_G, OP_EH,
            OP_D1, OP_D2, OP_MP1, OP_MP2, OP_MP3: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic prog_t prog_entry(pc_t pc);
        prog_t e;
        unique case (pc)
            5'd0:    e = '{OP_LOAD,  7'd1};
            5'd1:    e = '{OP_NORM,  7'd5};
            5'd2:    e = '{OP_SQ,    7'd24};
            5'd3:    e = '{OP_LOGL,  7'd1};
            5'd4:    e = '{OP_R2,    7'd1};
            5'd5:    e = '{OP_SQRT,  7'd32};
            5'd6:    e = '{OP_TH,    7'd1};
            5'd7:    e = '{OP_Y,     7'd1};
            5'd8:    e = '{OP_CH,    7'd6};
            5'd9:    e = '{OP_Z,     7'd1};
            5'd10:   e = '{OP_W,     7'd1};
            5'd11:   e = '{OP_X,     7'd1};
            5'd12:   e = '{OP_G,     7'd1};
            5'd13:   e = '{OP_EH,    7'd10};
            5'd14:   e = '{OP_D1,    7'd1};
            5'd15:   e = '{OP_D2,    7'd1};
            5'd16:   e = '{OP_PRICE, 7'd1};
            5'd17:   e = '{OP_PAY,   7'd1};
            5'd18:   e = '{OP_ACC,   7'd1};
            5'd19:   e = '{OP_DIVI,  7'd1};
            5'd20:   e = '{OP_DIV,   7'd64};
            5'd21:   e = '{OP_MP1,   7'd1};
            5'd22:   e = '{OP_MP2,   7'd1};
            5'd23:   e = '{OP_MP3,   7'd1};
            default: e = '{OP_NOP,   7'd1};
        endcase
        return e;
    endfunction

    function automatic logic [30:0] cos_coef(logic [2:0] k);
        logic [30:0] c;
        case (k)
            3'd0:    c = 31'd1073741824;
            3'd1:    c = 31'd536870912;
            3'd2:    c = 31'd44739243;
            3'd3:    c = 31'd1491308;
            3'd4:    c = 31'd26631;
            3'd5:    c = 31'd296;
            3'd6:    c = 31'd2;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

    function automatic logic [30:0] exp_coef(logic [3:0] k);
        logic [30:0] c;
        case (k)
            4'd0:    c = 31'd1073741824;
            4'd1:    c = 31'd1073741824;
            4'd2:    c = 31'd536870912;
            4'd3:    c = 31'd178956971;
            4'd4:    c = 31'd44739243;
            4'd5:    c = 31'd8947849;
            4'd6:    c = 31'd1491308;
            4'd7:    c = 31'd213044;
            4'd8:    c = 31'd26631;
            4'd9:    c = 31'd2959;
            4'd10:   c = 31'd296;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/mcop_ctrl.sv
`timescale 1ns / 1ps
// Sequencer state machine that steps the datapath through the lane and final programs.
module mcop_ctrl
    import mcop_pkg::*;
#(
    parameter int LANES  = 4,
    parameter int LANE_W = 2
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  stat_t             stat,
    output cmd_t              cmd,
    output logic [LANE_W-1:0] lane
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    pc_t               pc_reg, pc_next;
    logic [5:0]        step_reg, step_next;
    logic              phase_reg, phase_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              out_valid_reg, out_valid_next;
    prog_t             ent;
    logic              mul_op;
    logic              step_end;
    logic              lane_end;

    assign ent      = prog_entry(pc_reg);
    assign mul_op   = op_is_mul(ent.op);
    assign step_end = ({1'b0, step_reg} == (ent.reps - 7'd1));
    assign lane_end = (lane_reg == LANE_W'(LANES - 1));

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        lane_next  = lane_reg;
        cmd        = '{OP_NOP, 1'b0, 6'd0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_RUN;
                    pc_next    = '0;
                    step_next  = '0;
                    phase_next = 1'b0;
                    lane_next  = '0;
                end
            end
            ST_RUN:
            begin
                cmd = '{ent.op, phase_reg, step_reg};
                if (mul_op && !phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (step_end)
                    begin
                        step_next = '0;
                        if (pc_reg == PC_LANE_LAST)
                        begin
                            if (lane_end)
                            begin
                                lane_next = '0;
                                if (stat.last)
                                begin
                                    pc_next = PC_FINAL;
                                end
                                else
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                            else
                            begin
                                lane_next = lane_reg + 1'b1;
                                pc_next   = '0;
                            end
                        end
                        else if (pc_reg == PC_FINAL_LAST)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (cmd.op == OP_EMIT) || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign lane     = lane_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("emit did not return to idle with a valid result");

    a_phase_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.phase |-> op_is_mul(cmd.op))
        else $error("second phase issued for a non-multiply step");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ({1'b0, step_reg} < ent.reps))
        else $error("step count ran past the program entry");

endmodule

### rtl/mcop_dp.sv
`timescale 1ns / 1ps
// Datapath with a shared multiplier, lane registers, accumulator, divider and result registers.
module mcop_dp
    import mcop_pkg::*;
#(
    parameter int LANES  = 4,
    parameter int LANE_W = 2
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [LANE_W-1:0]     lane,
    input  cfg_t                  cfg,
    input  logic [64*LANES-1:0]   s_data,
    input  logic                  s_last,
    output stat_t                 stat,
    output logic [63:0]           payoff_sum,
    output logic [31:0]           path_count,
    output logic [47:0]           option_price
);

    logic [31:0] a_reg [LANES];
    logic [31:0] b_reg [LANES];
    logic        last_reg;
    logic [65:0] prod_reg, prod_next;
    logic [31:0] m_reg;
    logic [4:0]  s_reg;
    logic [23:0] frac_reg;
    logic [29:0] l_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic        neg_reg;
    logic [30:0] t_reg;
    logic [30:0] th_reg;
    logic [31:0] y_reg;
    logic [31:0] acc_reg;
    logic [27:0] zm_reg;
    logic [35:0] w_reg;
    logic        big_reg;
    logic        wz_reg;
    logic [6:0]  n_reg;
    logic [6:0]  nsh_reg;
    logic        usone_reg;
    logic [24:0] fe_reg;
    logic [30:0] g_reg;
    logic [55:0] hi_reg;
    logic [51:0] tm_reg;
    logic [47:0] price_reg;
    logic [47:0] pay_reg;
    logic [63:0] sum_reg;
    logic [31:0] cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] quot_reg;
    logic [40:0] p1_reg;
    logic [48:0] p2_reg;
    logic [63:0] out_sum_reg;
    logic [31:0] out_cnt_reg;
    logic [47:0] out_price_reg;

    logic [31:0] a_sel, b_sel, a_nz;
    logic [32:0] t1;
    logic        fold_neg;
    logic [30:0] t_fold;
    logic        norm_zero;
    logic [4:0]  norm_sh;
    logic [32:0] m2;
    logic [5:0]  e_top;
    logic [29:0] l_calc;
    logic [63:0] sq_bit, sq_try;
    logic [30:0] ch_coef;
    logic [31:0] ch_p;
    logic [31:0] ch_val;
    logic [30:0] x_val;
    logic        pos;
    logic [23:0] x_f;
    logic [33:0] eh_sum;
    logic [31:0] mexp;
    logic [56:0] d2_mid;
    logic [51:0] tm_calc;
    logic [47:0] lim;
    logic [51:0] tm_shl, tm_shr;
    logic [47:0] price_calc;
    logic [47:0] pay_calc;
    logic [64:0] sum_add;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [24:0] disc;
    logic [49:0] mp_tot;
    logic [47:0] mean_price;
    logic [32:0] mul_a, mul_b;

    assign a_sel = a_reg[lane];
    assign b_sel = b_reg[lane];
    assign a_nz  = (a_sel == 32'd0) ? 32'd1 : a_sel;

    // Fold the angle into the first quadrant and remember the sign of the cosine.
    assign t1       = b_sel[31] ? (33'h1_0000_0000 - {1'b0, b_sel}) : {1'b0, b_sel};
    assign fold_neg = (t1 > 33'd1073741824);
    assign t_fold   = fold_neg ? 31'(33'h0_8000_0000 - t1) : t1[30:0];

    always_comb
    begin
        case (cmd.step[2:0])
            3'd0:
            begin
                norm_zero = (m_reg[31:16] == 16'd0);
                norm_sh   = 5'd16;
            end
            3'd1:
            begin
                norm_zero = (m_reg[31:24] == 8'd0);
                norm_sh   = 5'd8;
            end
            3'd2:
            begin
                norm_zero = (m_reg[31:28] == 4'd0);
                norm_sh   = 5'd4;
            end
            3'd3:
            begin
                norm_zero = (m_reg[31:30] == 2'd0);
                norm_sh   = 5'd2;
            end
            3'd4:
            begin
                norm_zero = !m_reg[31];
                norm_sh   = 5'd1;
            end
            default:
            begin
                norm_zero = 1'b0;
                norm_sh   = 5'd0;
            end
        endcase
    end

    assign m2     = prod_reg[63:31];
    assign e_top  = {1'b0, s_reg} + 6'd1;
    assign l_calc = {e_top, 24'd0} - {6'd0, frac_reg};

    assign sq_bit = 64'd1 << (7'd62 - {cmd.step, 1'b0});
    assign sq_try = res_reg + sq_bit;

    assign ch_coef = cos_coef(3'd5 - cmd.step[2:0]);
    assign ch_p    = prod_reg[61:30];
    assign ch_val  = (ch_p > {1'b0, ch_coef}) ? 32'd0 : ({1'b0, ch_coef} - ch_p);

    assign x_val = prod_reg[60:30];
    assign x_f   = x_val[23:0];
    assign pos   = !neg_reg || wz_reg;

    assign eh_sum = {3'd0, exp_coef(4'd9 - cmd.step[3:0])} + {1'b0, prod_reg[62:30]};

    assign mexp    = usone_reg ? ONE_Q30 : acc_reg;
    assign d2_mid  = {27'd0, hi_reg[5:0], 24'd0} + {1'b0, prod_reg[55:0]};
    assign tm_calc = {2'd0, hi_reg[55:6]} + {25'd0, d2_mid[56:30]};

    assign lim    = PRICE_MAX >> n_reg[5:0];
    assign tm_shl = tm_reg << n_reg[5:0];
    assign tm_shr = tm_reg >> nsh_reg;

    always_comb
    begin
        if (cfg.drift_scale == 48'd0)
        begin
            price_calc = 48'd0;
        end
        else if (big_reg)
        begin
            price_calc = neg_reg ? 48'd0 : PRICE_MAX;
        end
        else if (pos)
        begin
            if (n_reg >= 7'd48 || tm_reg > {4'd0, lim})
            begin
                price_calc = PRICE_MAX;
            end
            else
            begin
                price_calc = tm_shl[47:0];
            end
        end
        else
        begin
            price_calc = tm_shr[47:0];
        end
    end

    always_comb
    begin
        if (cfg.is_call)
        begin
            pay_calc = (price_reg > cfg.strike) ? (price_reg - cfg.strike) : 48'd0;
        end
        else
        begin
            pay_calc = (cfg.strike > price_reg) ? (cfg.strike - price_reg) : 48'd0;
        end
    end

    assign sum_add = {1'b0, sum_reg} + {17'd0, pay_reg};

    assign div_sh = {rem_reg, quot_reg[63]};
    assign div_ge = (div_sh >= {1'b0, cnt_reg});

    assign disc       = (cfg.discount > ONE_Q24) ? ONE_Q24 : cfg.discount;
    assign mp_tot     = {2'd0, p1_reg[23:0], 24'd0} + {1'b0, p2_reg} + {25'd0, prod_reg[48:24]};
    assign mean_price = ((p1_reg[40:24] != 17'd0) || (mp_tot > {2'd0, PRICE_MAX}))
                      ? PRICE_MAX : mp_tot[47:0];

    always_comb
    begin
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            OP_R2:
            begin
                mul_a = {3'd0, l_reg};
                mul_b = TWO_LN2_Q30;
            end
            OP_TH:
            begin
                mul_a = {2'd0, t_reg};
                mul_b = TWO_PI_Q30;
            end
            OP_Y:
            begin
                mul_a = {2'd0, th_reg};
                mul_b = {2'd0, th_reg};
            end
            OP_CH:
            begin
                mul_a = {1'b0, acc_reg};
                mul_b = {1'b0, y_reg};
            end
            OP_Z:
            begin
                mul_a = {1'b0, res_reg[31:0]};
                mul_b = {1'b0, acc_reg};
            end
            OP_W:
            begin
                mul_a = {1'b0, cfg.vol_scale};
                mul_b = {5'd0, zm_reg};
            end
            OP_X:
            begin
                mul_a = {3'd0, w_reg[29:0]};
                mul_b = INV_LN2_Q30;
            end
            OP_G:
            begin
                mul_a = {8'd0, fe_reg};
                mul_b = LN2_Q30;
            end
            OP_EH:
            begin
                mul_a = {1'b0, acc_reg};
                mul_b = {2'd0, g_reg};
            end
            OP_D1:
            begin
                mul_a = {9'd0, cfg.drift_scale[47:24]};
                mul_b = {1'b0, mexp};
            end
            OP_D2:
            begin
                mul_a = {9'd0, cfg.drift_scale[23:0]};
                mul_b = {1'b0, mexp};
            end
            OP_MP1:
            begin
                mul_a = {17'd0, quot_reg[63:48]};
                mul_b = {8'd0, disc};
            end
            OP_MP2:
            begin
                mul_a = {9'd0, quot_reg[47:24]};
                mul_b = {8'd0, disc};
            end
            OP_MP3:
            begin
                mul_a = {9'd0, quot_reg[23:0]};
                mul_b = {8'd0, disc};
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 33'd0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (op_is_mul(cmd.op) && !cmd.phase)
        begin
            prod_reg <= prod_next;
        end
        else
        begin
            unique case (cmd.op)
                OP_CAPTURE:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        a_reg[i] <= s_data[64*i +: 32];
                        b_reg[i] <= s_data[64*i+32 +: 32];
                    end
                    last_reg <= s_last;
                end
                OP_LOAD:
                begin
                    m_reg    <= a_nz;
                    s_reg    <= 5'd0;
                    frac_reg <= 24'd0;
                    t_reg    <= t_fold;
                    neg_reg  <= fold_neg;
                end
                OP_NORM:
                begin
                    if (norm_zero)
                    begin
                        m_reg <= m_reg << norm_sh;
                        s_reg <= s_reg + norm_sh;
                    end
                end
                OP_SQ:
                begin
                    frac_reg <= {frac_reg[22:0], m2[32]};
                    m_reg    <= m2[32] ? m2[32:1] : m2[31:0];
                end
                OP_LOGL:
                begin
                    l_reg <= l_calc;
                end
                OP_R2:
                begin
                    v_reg   <= {10'd0, prod_reg[59:30], 24'd0};
                    res_reg <= 64'd0;
                end
                OP_SQRT:
                begin
                    if (v_reg >= sq_try)
                    begin
                        v_reg   <= v_reg - sq_try;
                        res_reg <= (res_reg >> 1) + sq_bit;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                end
                OP_TH:
                begin
                    th_reg <= prod_reg[62:32];
                end
                OP_Y:
                begin
                    y_reg   <= prod_reg[61:30];
                    acc_reg <= {1'b0, cos_coef(3'd6)};
                end
                OP_CH:
                begin
                    acc_reg <= ch_val;
                end
                OP_Z:
                begin
                    zm_reg <= prod_reg[57:30];
                end
                OP_W:
                begin
                    w_reg   <= prod_reg[59:24];
                    big_reg <= (prod_reg[59:54] != 6'd0);
                    wz_reg  <= (prod_reg[59:24] == 36'd0);
                end
                OP_X:
                begin
                    n_reg     <= x_val[30:24];
                    fe_reg    <= pos ? {1'b0, x_f}
                               : ((x_f != 24'd0) ? (ONE_Q24 - {1'b0, x_f}) : 25'd0);
                    usone_reg <= !pos && (x_f == 24'd0);
                    nsh_reg   <= (!pos && (x_f != 24'd0)) ? (x_val[30:24] + 7'd1)
                                                          : x_val[30:24];
                end
                OP_G:
                begin
                    g_reg   <= prod_reg[54:24];
                    acc_reg <= {1'b0, exp_coef(4'd10)};
                end
                OP_EH:
                begin
                    acc_reg <= eh_sum[31:0];
                end
                OP_D1:
                begin
                    hi_reg <= prod_reg[55:0];
                end
                OP_D2:
                begin
                    tm_reg <= tm_calc;
                end
                OP_PRICE:
                begin
                    price_reg <= price_calc;
                end
                OP_PAY:
                begin
                    pay_reg <= pay_calc;
                end
                OP_DIVI:
                begin
                    rem_reg  <= 32'd0;
                    quot_reg <= sum_reg;
                end
                OP_DIV:
                begin
                    rem_reg  <= div_ge ? 32'(div_sh - {1'b0, cnt_reg}) : div_sh[31:0];
                    quot_reg <= {quot_reg[62:0], div_ge};
                end
                OP_MP1:
                begin
                    p1_reg <= prod_reg[40:0];
                end
                OP_MP2:
                begin
                    p2_reg <= prod_reg[48:0];
                end
                OP_MP3:
                begin
                    price_reg <= mean_price;
                end
                OP_EMIT:
                begin
                    out_sum_reg   <= sum_reg;
                    out_cnt_reg   <= cnt_reg;
                    out_price_reg <= price_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 64'd0;
            cnt_reg <= 32'd0;
        end
        else if (cmd.op == OP_ACC)
        begin
            sum_reg <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
            cnt_reg <= (cnt_reg == 32'hFFFF_FFFF) ? cnt_reg : (cnt_reg + 32'd1);
        end
        else if (cmd.op == OP_EMIT)
        begin
            sum_reg <= 64'd0;
            cnt_reg <= 32'd0;
        end
    end

    assign stat.last    = last_reg;
    assign payoff_sum   = out_sum_reg;
    assign path_count   = out_cnt_reg;
    assign option_price = out_price_reg;

endmodule

### rtl/monte_carlo_option_payoff.sv
`timescale 1ns / 1ps
// Top level: configuration registers, stream packing, sequencer and datapath.
// A word is accepted only when the block is idle; its lanes run one after another through
// a shared multiplier, so the block takes no new word until all of its lanes are done.
// A word marked last adds the 64-step divider, scaling and result capture.
// The result register frees the block at once; a second result waits only for the first.
// Reset clears the sum and path count, loads register defaults and drops the result valid.
module monte_carlo_option_payoff
    import mcop_pkg::*;
#(
    parameter int LANES = 4
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // Per lane from lane 0 up: uniform_a, uniform_b, 32 bits each.
    input  logic [64*LANES-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0 up: payoff_sum (64), path_count (32), option_price (48).
    output logic [143:0]        m_tdata,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    cfg_t              cfg_reg;
    cmd_t              cmd;
    stat_t             stat;
    logic [LANE_W-1:0] lane;
    logic [63:0]       payoff_sum;
    logic [31:0]       path_count;
    logic [47:0]       option_price;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drift_scale <= 48'd0;
            cfg_reg.vol_scale   <= 32'd0;
            cfg_reg.strike      <= 48'd0;
            cfg_reg.is_call     <= 1'b1;
            cfg_reg.discount    <= ONE_Q24;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DRIFT:  cfg_reg.drift_scale <= cfg_data;
                REG_VOL:    cfg_reg.vol_scale   <= cfg_data[31:0];
                REG_STRIKE: cfg_reg.strike      <= cfg_data;
                REG_CALL:   cfg_reg.is_call     <= cfg_data[0];
                REG_DISC:   cfg_reg.discount    <= cfg_data[24:0];
                default:
                begin
                end
            endcase
        end
    end

    mcop_ctrl #(
        .LANES  (LANES),
        .LANE_W (LANE_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .lane     (lane)
    );

    mcop_dp #(
        .LANES  (LANES),
        .LANE_W (LANE_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .lane         (lane),
        .cfg          (cfg_reg),
        .s_data       (s_tdata),
        .s_last       (s_tlast),
        .stat         (stat),
        .payoff_sum   (payoff_sum),
        .path_count   (path_count),
        .option_price (option_price)
    );

    assign m_tdata = {option_price, path_count, payoff_sum};

endmodule
